### rtl/core/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants for the parameter set tracker.
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int SEQ_SETS_DEF = 32;
	localparam int PIC_SETS_DEF = 256;
	localparam int QUEUE_DEPTH  = 4;

	typedef enum logic [1:0] {
		OP_HEADER = 2'd0,
		OP_DESC   = 2'd1,
		OP_BYTE   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		UT_SPS   = 2'd0,
		UT_PPS   = 2'd1,
		UT_IDR   = 2'd2,
		UT_OTHER = 2'd3
	} unit_t;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DROP   = 2'd1,
		ACT_KEY    = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		PH_AGG_HDR = 2'd0,
		PH_LEN_HI  = 2'd1,
		PH_LEN_LO  = 2'd2,
		PH_BODY    = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        first_in_frame;
		logic        is_aggregate;
		logic        has_units;
		logic [15:0] frame_width;
		logic [15:0] frame_height;
		logic [1:0]  unit_type;
		logic [4:0]  seq_set_id;
		logic [7:0]  pic_set_id;
		logic        pic_set_present;
		logic [7:0]  data_byte;
		logic        byte_last;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  out_byte;
		logic [1:0]  action;
		logic [15:0] out_width;
		logic [15:0] out_height;
		logic        run_last;
	} out_item_t;

	// one expansion job handed from front to back
	typedef struct packed {
		logic        start;     // emit start code first
		logic        data_en;   // emit the byte
		logic [7:0]  data;
		logic        verdict;   // emit a verdict at the end
		logic [1:0]  action;
		logic [15:0] width;
		logic [15:0] height;
	} job_t;

endpackage

### rtl/core/pst_front.sv
// ----------------------------------------------------------------------------
// pst_front
// Parameter set tables, packet state and deframing; emits expansion jobs.
// ----------------------------------------------------------------------------
module pst_front import pst_pkg::*; #(
	parameter int SEQ_SETS = SEQ_SETS_DEF,
	parameter int PIC_SETS = PIC_SETS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_item_t in_data,
	output logic     in_stall,
	output logic     job_valid,
	output job_t     job,
	input  logic     job_full
);
	localparam int SW = (SEQ_SETS > 1) ? $clog2(SEQ_SETS) : 1;
	localparam int PW = (PIC_SETS > 1) ? $clog2(PIC_SETS) : 1;

	logic [SEQ_SETS-1:0] seq_vld_q;
	logic [31:0]         seq_sz_q [SEQ_SETS];
	logic [PIC_SETS-1:0] pic_vld_q;
	logic [4:0]          pic_sid_q [PIC_SETS];

	logic        pend_key_q;
	logic [2:0]  flags_q;
	logic [15:0] cur_w_q, cur_h_q;
	phase_t      phase_q;
	logic [7:0]  len_hi_q;
	logic [15:0] left_q;
	logic        first_q;

	// IDR lookup: PPS memory read at accept, SPS resolved in the next cycle
	logic        idr_s1, pic_hit_s1;
	logic [4:0]  pic_rd_s1;

	logic acc;
	assign in_stall = job_full;
	assign acc      = in_valid && !job_full;

	// lookup paths
	logic        sid_ok, pid_ok, pic_hit, seq_hit;
	logic [4:0]  ref_sid;
	logic [31:0] seq_sz;
	assign sid_ok  = 32'(in_data.seq_set_id) < 32'(SEQ_SETS);
	assign pid_ok  = 32'(in_data.pic_set_id) < 32'(PIC_SETS);
	assign pic_hit = in_data.pic_set_present && pid_ok && pic_vld_q[in_data.pic_set_id[PW-1:0]];
	assign ref_sid = pic_rd_s1;
	assign seq_hit = pic_hit_s1 && (32'(ref_sid) < 32'(SEQ_SETS)) && seq_vld_q[ref_sid[SW-1:0]];
	assign seq_sz  = seq_sz_q[ref_sid[SW-1:0]];

	// packet state as seen by the current request, with a staged IDR applied
	logic        pend_eff, pend_d, idr_take;
	logic [15:0] w_eff, h_eff, w_d, h_d;
	assign pend_eff = pend_key_q || (idr_s1 && !seq_hit);
	assign w_eff    = (idr_s1 && seq_hit) ? seq_sz[31:16] : cur_w_q;
	assign h_eff    = (idr_s1 && seq_hit) ? seq_sz[15:0] : cur_h_q;
	assign idr_take = acc && in_data.op == OP_DESC && in_data.unit_type == UT_IDR &&
		!pend_eff && flags_q[0];

	always_comb begin
		pend_d = pend_eff;
		w_d    = w_eff;
		h_d    = h_eff;
		if (acc && in_data.op == OP_HEADER) begin
			pend_d = 1'b0;
			w_d    = in_data.frame_width;
			h_d    = in_data.frame_height;
		end
	end

	// byte path
	logic        bt_start, bt_data, bt_cut;
	phase_t      ph_d;
	logic [15:0] left_d, len_full, left_dec;
	assign len_full = {len_hi_q, in_data.data_byte};
	assign left_dec = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;

	always_comb begin
		bt_start = 1'b0;
		bt_data  = 1'b0;
		bt_cut   = 1'b0;
		ph_d     = phase_q;
		left_d   = left_q;
		if (!pend_eff) begin
			if (flags_q[1]) begin
				case (phase_q)
					PH_AGG_HDR: ph_d = PH_LEN_HI;
					PH_LEN_HI: begin
						bt_start = 1'b1;
						ph_d     = PH_LEN_LO;
						bt_cut   = in_data.byte_last;
					end
					PH_LEN_LO: begin
						left_d = len_full;
						ph_d   = (len_full != 16'd0) ? PH_BODY : PH_LEN_HI;
						bt_cut = in_data.byte_last && len_full != 16'd0;
					end
					default: begin
						bt_data = 1'b1;
						left_d  = left_dec;
						if (left_dec == 16'd0)
							ph_d = PH_LEN_HI;
						bt_cut = in_data.byte_last && left_dec != 16'd0;
					end
				endcase
			end else begin
				bt_start = first_q && flags_q[2];
				bt_data  = 1'b1;
			end
		end
	end

	always_comb begin
		job_valid   = acc && in_data.op == OP_BYTE;
		job.start   = bt_start;
		job.data_en = bt_data;
		job.data    = in_data.data_byte;
		job.verdict = in_data.byte_last;
		job.action  = bt_cut ? ACT_DROP : (pend_eff ? ACT_KEY : ACT_INSERT);
		job.width   = w_eff;
		job.height  = h_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_vld_q  <= '0;
			pic_vld_q  <= '0;
			pend_key_q <= 1'b0;
			flags_q    <= '0;
			cur_w_q    <= '0;
			cur_h_q    <= '0;
			phase_q    <= PH_AGG_HDR;
			len_hi_q   <= '0;
			left_q     <= '0;
			first_q    <= 1'b1;
			idr_s1     <= 1'b0;
			pic_hit_s1 <= 1'b0;
		end else begin
			pend_key_q <= pend_d;
			cur_w_q    <= w_d;
			cur_h_q    <= h_d;
			idr_s1     <= idr_take;
			pic_hit_s1 <= pic_hit;
			if (acc) begin
				case (in_data.op)
					OP_HEADER: begin
						flags_q  <= {in_data.has_units, in_data.is_aggregate,
							in_data.first_in_frame};
						phase_q  <= PH_AGG_HDR;
						len_hi_q <= '0;
						left_q   <= '0;
						first_q  <= 1'b1;
					end
					OP_DESC: begin
						if (!pend_eff) begin
							case (in_data.unit_type)
								UT_SPS: if (sid_ok)
									seq_vld_q[in_data.seq_set_id[SW-1:0]] <= 1'b1;
								UT_PPS: if (in_data.pic_set_present && pid_ok)
									pic_vld_q[in_data.pic_set_id[PW-1:0]] <= 1'b1;
								default: ;
							endcase
						end
					end
					OP_BYTE: begin
						// restart the deframer after the last byte
						first_q <= in_data.byte_last;
						if (in_data.byte_last) begin
							phase_q  <= PH_AGG_HDR;
							len_hi_q <= '0;
							left_q   <= '0;
						end else begin
							phase_q <= ph_d;
							left_q  <= left_d;
							if (!pend_eff && flags_q[1] && phase_q == PH_LEN_HI)
								len_hi_q <= in_data.data_byte;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// table payload, no reset; PPS memory has a registered read
	always_ff @(posedge clk) begin
		pic_rd_s1 <= pic_sid_q[in_data.pic_set_id[PW-1:0]];
		if (acc && in_data.op == OP_DESC && !pend_eff) begin
			if (in_data.unit_type == UT_SPS && sid_ok)
				seq_sz_q[in_data.seq_set_id[SW-1:0]] <= {w_eff, h_eff};
			if (in_data.unit_type == UT_PPS && in_data.pic_set_present && pid_ok)
				pic_sid_q[in_data.pic_set_id[PW-1:0]] <= in_data.seq_set_id;
		end
	end

	ap_no_job_on_header: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_data.op == OP_HEADER) |-> !job_valid)
		else $error("job issued on header");
	ap_key_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && pend_eff) |-> (!job.data_en && !job.start))
		else $error("output while key frame pending");
	ap_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job.verdict) |=> (phase_q == PH_AGG_HDR && first_q))
		else $error("deframer not restarted");
endmodule

### rtl/core/pst_back.sv
// ----------------------------------------------------------------------------
// pst_back
// Job queue and expander: turns each job into stream bytes and a verdict.
// ----------------------------------------------------------------------------
module pst_back import pst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	input  job_t      job,
	output logic      job_full,
	output logic      out_valid,
	output out_item_t out_data,
	input  logic      out_stall
);
	localparam int AW = $clog2(QUEUE_DEPTH);

	job_t          q_mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic [2:0]    step_q;   // 0..3 start code, 4 data, 5 verdict

	logic  empty, pop;
	job_t  head;
	assign empty    = cnt_q == '0;
	assign job_full = cnt_q == (AW+1)'(QUEUE_DEPTH);
	assign head     = q_mem_q[rd_q];

	// find current and next emitting step of the head job
	logic [2:0] cur, nxt;
	logic       has_nxt;
	always_comb begin
		cur = step_q;
		if (cur < 3'd4 && !head.start) cur = 3'd4;
		if (cur == 3'd4 && !head.data_en) cur = 3'd5;
		nxt = cur + 3'd1;
		if (nxt == 3'd4 && !head.data_en) nxt = 3'd5;
		has_nxt = (nxt < 3'd5) || (nxt == 3'd5 && head.verdict);
	end

	logic live;
	assign live      = !empty && (cur < 3'd5 || head.verdict);
	assign out_valid = live;
	always_comb begin
		out_data          = '0;
		out_data.run_last = !has_nxt;
		if (cur == 3'd5) begin
			out_data.kind       = 1'b1;
			out_data.action     = head.action;
			out_data.out_width  = head.width;
			out_data.out_height = head.height;
		end else if (cur == 3'd4) begin
			out_data.out_byte = head.data;
		end else begin
			out_data.out_byte = (cur == 3'd3) ? 8'd1 : 8'd0;
		end
	end

	// jobs producing nothing are dropped at once
	logic adv;
	assign adv = live && !out_stall;
	assign pop = (!empty && !live) || (adv && !has_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			cnt_q  <= '0;
			step_q <= '0;
		end else begin
			if (job_valid) wr_q <= wr_q + AW'(1);
			if (pop) begin
				rd_q   <= rd_q + AW'(1);
				step_q <= '0;
			end else if (adv) begin
				step_q <= nxt;
			end
			cnt_q <= cnt_q + (AW+1)'(job_valid) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid) q_mem_q[wr_q] <= job;
	end

	ap_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_full |-> !job_valid)
		else $error("queue overflow");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");
	ap_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");
endmodule

### rtl/core/h264_param_set_tracker_annexb.sv
// ----------------------------------------------------------------------------
// h264_param_set_tracker_annexb
// Parameter set tracker and packet payload to Annex B stream converter.
// ----------------------------------------------------------------------------
// One request is accepted per cycle while the four-entry job queue has room.
// The front tracks the SPS table and the PPS valid bits in flip-flops (the
// valid bits cleared at reset), the PPS sequence ids in a memory with a
// registered read, packet state and the aggregation deframer, and turns every
// payload byte into one job. An IDR descriptor reads the PPS memory when
// accepted and is resolved against the SPS table in the next cycle; the
// outcome is forwarded to the request accepted in that cycle, so descriptors
// never cause a stall. The back expands each job at one result per cycle
// while the output is not stalled: up to a four-byte start code, the byte
// itself and, on a packet's last byte, the verdict. The first result of a
// byte is read from the job queue entry written when the byte is accepted.
// Sustained rate is one byte per cycle outside start code bursts and output
// stalls; bursts are absorbed by the queue, and a full queue raises in stall.
// ----------------------------------------------------------------------------
module h264_param_set_tracker_annexb import pst_pkg::*; #(
	parameter int SEQ_SETS = SEQ_SETS_DEF,
	parameter int PIC_SETS = PIC_SETS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  in_item_t  in_data,
	output logic      in_stall,
	output logic      out_valid,
	output out_item_t out_data,
	input  logic      out_stall
);
	logic job_valid, job_full;
	job_t job;

	// classify requests and update tables
	pst_front #(.SEQ_SETS(SEQ_SETS), .PIC_SETS(PIC_SETS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
		.job_valid(job_valid), .job(job), .job_full(job_full)
	);

	// queue and expand into results
	pst_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job(job), .job_full(job_full),
		.out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
	);
endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the parameter set tracker and Annex B converter.
// A directed table covers parameter set learning, key frame requests,
// aggregation deframing with truncated and cut lengths, and packets with no
// start code. Random packets, mostly well formed, follow. Every accepted request is run
// through a local predictor, and each output result is checked in order
// against the predicted stream under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
	import pst_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	in_item_t  in_data;
	logic      in_stall;
	logic      out_valid;
	out_item_t out_data;
	logic      out_stall;

	h264_param_set_tracker_annexb u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_data (out_data),
		.out_stall(out_stall)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// predictor state: parameter set tables and current packet context
	logic        sps_valid [SEQ_SETS_DEF];
	logic [15:0] sps_width [SEQ_SETS_DEF];
	logic [15:0] sps_height[SEQ_SETS_DEF];
	logic        pps_valid [PIC_SETS_DEF];
	logic [4:0]  pps_sps   [PIC_SETS_DEF];
	act_t        pend_act;
	logic        pk_first, pk_agg, pk_units;
	logic [15:0] pk_width, pk_height;
	phase_t      phase;
	logic [7:0]  len_hi;
	logic [15:0] body_left;
	logic        at_first_byte;

	out_item_t   expected_q[$];
	int          errors;
	int          idle_pct;
	int          stall_pct;
	int          quiet;

	task automatic report(input string msg);
		$display("tb: mismatch: %s", msg);
		errors++;
	endtask

	function automatic out_item_t stream_byte(input logic [7:0] b);
		out_item_t r;
		r = '0;
		r.out_byte = b;
		return r;
	endfunction

	task automatic push_start_code(ref out_item_t res[$]);
		res = {res, stream_byte(8'h00), stream_byte(8'h00), stream_byte(8'h00),
			stream_byte(8'h01)};
	endtask

	task automatic reset_tracker();
		for (int i = 0; i < SEQ_SETS_DEF; i++) sps_valid[i] = 1'b0;
		for (int i = 0; i < PIC_SETS_DEF; i++) pps_valid[i] = 1'b0;
		pend_act = ACT_INSERT;
		{pk_first, pk_agg, pk_units} = '0;
		pk_width = '0;
		pk_height = '0;
		phase = PH_AGG_HDR;
		len_hi = '0;
		body_left = '0;
		at_first_byte = 1'b1;
	endtask

	// advance the tracker by one request and append the stream it causes
	task automatic track_request(input in_item_t req);
		out_item_t res[$];
		out_item_t v;
		logic      cut;
		logic [4:0] s;
		cut = 1'b0;
		case (op_t'(req.op))
			OP_HEADER: begin
				pk_first = req.first_in_frame;
				pk_agg = req.is_aggregate;
				pk_units = req.has_units;
				pk_width = req.frame_width;
				pk_height = req.frame_height;
				pend_act = ACT_INSERT;
				phase = PH_AGG_HDR;
				len_hi = '0;
				body_left = '0;
				at_first_byte = 1'b1;
			end
			OP_DESC: begin
				if (pend_act == ACT_INSERT) begin
					case (unit_t'(req.unit_type))
						UT_SPS: begin
							sps_valid[req.seq_set_id] = 1'b1;
							sps_width[req.seq_set_id] = pk_width;
							sps_height[req.seq_set_id] = pk_height;
						end
						UT_PPS: begin
							if (req.pic_set_present) begin
								pps_valid[req.pic_set_id] = 1'b1;
								pps_sps[req.pic_set_id] = req.seq_set_id;
							end
						end
						UT_IDR: begin
							if (pk_first) begin
								if (!req.pic_set_present || !pps_valid[req.pic_set_id]) begin
									pend_act = ACT_KEY;
								end else begin
									s = pps_sps[req.pic_set_id];
									if (!sps_valid[s]) begin
										pend_act = ACT_KEY;
									end else begin
										pk_width = sps_width[s];
										pk_height = sps_height[s];
									end
								end
							end
						end
						default: ;
					endcase
				end
			end
			OP_BYTE: begin
				if (pend_act == ACT_INSERT) begin
					if (pk_agg) begin
						case (phase)
							PH_AGG_HDR: phase = PH_LEN_HI;
							PH_LEN_HI: begin
								push_start_code(res);
								len_hi = req.data_byte;
								phase = PH_LEN_LO;
								cut = req.byte_last;
							end
							PH_LEN_LO: begin
								body_left = {len_hi, req.data_byte};
								phase = (body_left != 0) ? PH_BODY : PH_LEN_HI;
								cut = req.byte_last && body_left != 0;
							end
							default: begin
								res = {res, stream_byte(req.data_byte)};
								if (body_left != 0) body_left--;
								if (body_left == 0) phase = PH_LEN_HI;
								cut = req.byte_last && body_left != 0;
							end
						endcase
					end else begin
						if (at_first_byte && pk_units) push_start_code(res);
						res = {res, stream_byte(req.data_byte)};
					end
				end
				at_first_byte = 1'b0;
				if (req.byte_last) begin
					v = '0;
					v.kind = 1'b1;
					v.action = cut ? ACT_DROP : pend_act;
					v.out_width = pk_width;
					v.out_height = pk_height;
					res = {res, v};
					phase = PH_AGG_HDR;
					len_hi = '0;
					body_left = '0;
					at_first_byte = 1'b1;
				end
			end
			default: ;
		endcase
		if (res.size() > 0) res[res.size() - 1].run_last = 1'b1;
		expected_q = {expected_q, res};
	endtask

	// request builders
	function automatic in_item_t mk_hdr(input logic f, input logic a, input logic u,
			input logic [15:0] w, input logic [15:0] h);
		in_item_t r;
		r = '0;
		r.op = OP_HEADER;
		r.first_in_frame = f;
		r.is_aggregate = a;
		r.has_units = u;
		r.frame_width = w;
		r.frame_height = h;
		return r;
	endfunction

	function automatic in_item_t mk_desc(input unit_t t, input logic [4:0] sid,
			input logic [7:0] pid, input logic pp);
		in_item_t r;
		r = '0;
		r.op = OP_DESC;
		r.unit_type = t;
		r.seq_set_id = sid;
		r.pic_set_id = pid;
		r.pic_set_present = pp;
		return r;
	endfunction

	function automatic in_item_t mk_byte(input logic [7:0] b, input logic last);
		in_item_t r;
		r = '0;
		r.op = OP_BYTE;
		r.data_byte = b;
		r.byte_last = last;
		return r;
	endfunction

	// fill unused fields with noise so every bit toggles
	function automatic in_item_t noisy(input in_item_t r);
		in_item_t n;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		n = raw[$bits(in_item_t)-1:0];
		case (op_t'(r.op))
			OP_HEADER: begin
				n.op = r.op;
				n.first_in_frame = r.first_in_frame;
				n.is_aggregate = r.is_aggregate;
				n.has_units = r.has_units;
				n.frame_width = r.frame_width;
				n.frame_height = r.frame_height;
			end
			OP_DESC: begin
				n.op = r.op;
				n.unit_type = r.unit_type;
				n.seq_set_id = r.seq_set_id;
				n.pic_set_id = r.pic_set_id;
				n.pic_set_present = r.pic_set_present;
			end
			OP_BYTE: begin
				n.op = r.op;
				n.data_byte = r.data_byte;
				n.byte_last = r.byte_last;
			end
			default: n.op = r.op;
		endcase
		return n;
	endfunction

	// hand one request to the block and predict its results
	task automatic send(input in_item_t req);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_request(req);
		@(negedge clk);
	endtask

	// stall the output side at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// compare accepted results in order; count cycles with no handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report($sformatf("unexpected result %h", out_data));
				end else begin
					out_item_t e;
					e = expected_q.pop_front();
					if (out_data.kind !== e.kind)
						report($sformatf("kind %b exp %b", out_data.kind, e.kind));
					if (out_data.out_byte !== e.out_byte)
						report($sformatf("out_byte %h exp %h", out_data.out_byte, e.out_byte));
					if (out_data.action !== e.action)
						report($sformatf("action %0d exp %0d", out_data.action, e.action));
					if (out_data.out_width !== e.out_width)
						report($sformatf("out_width %0d exp %0d", out_data.out_width, e.out_width));
					if (out_data.out_height !== e.out_height)
						report($sformatf("out_height %0d exp %0d", out_data.out_height, e.out_height));
					if (out_data.run_last !== e.run_last)
						report($sformatf("run_last %b exp %b", out_data.run_last, e.run_last));
				end
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet = 0;
			else quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("tb: watchdog expired");
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	// one random packet: mostly well formed, sometimes broken
	task automatic random_packet();
		int nd, nb, len, k;
		logic [15:0] w, h;
		w = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
		h = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
		send(noisy(mk_hdr(1'($urandom_range(1)), 1'($urandom_range(1)),
			$urandom_range(3) != 0, w, h)));
		nd = $urandom_range(3);
		for (int i = 0; i < nd; i++)
			send(noisy(mk_desc(unit_t'(2'($urandom_range(3))), 5'($urandom_range(7)),
				($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
				$urandom_range(7) != 0)));
		if ($urandom_range(19) == 0) send(noisy('{op: OP_NONE, default: '0}));
		if ($urandom_range(1)) begin
			// aggregation body: header byte then a few length-prefixed units
			send(noisy(mk_byte(8'($urandom), 1'b0)));
			k = $urandom_range(1, 3);
			for (int u = 0; u < k; u++) begin
				len = $urandom_range(4);
				send(noisy(mk_byte(8'(len >> 8), 1'b0)));
				send(noisy(mk_byte(8'(len), 1'b0)));
				for (int j = 0; j < len; j++) send(noisy(mk_byte(8'($urandom), 1'b0)));
			end
			if ($urandom_range(4) == 0) send(noisy(mk_byte(8'($urandom), 1'b0)));
			if ($urandom_range(9) != 0) send(noisy(mk_byte(8'($urandom), 1'b1)));
		end else begin
			nb = $urandom_range(1, 6);
			for (int j = 0; j < nb; j++) send(noisy(mk_byte(8'($urandom), j == nb - 1)));
		end
	endtask

	typedef struct {
		in_item_t  req;
		bit        typed;
		out_item_t res;
	} row_t;

	row_t directed[$];

	task automatic add(input in_item_t r);
		row_t x;
		x.req = r;
		x.typed = 1'b0;
		x.res = '0;
		directed = {directed, x};
	endtask

	task automatic add_verdict(input in_item_t r, input act_t a, input logic [15:0] w,
			input logic [15:0] h);
		row_t x;
		x.req = r;
		x.typed = 1'b1;
		x.res = '{kind: 1'b1, out_byte: 8'h00, action: a, out_width: w, out_height: h,
			run_last: 1'b1};
		directed = {directed, x};
	endtask

	initial begin
		out_item_t chk;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		quiet = 0;
		reset_tracker();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// key frame request on an IDR with unknown sets, right after reset
		add(mk_hdr(1'b1, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF));
		add(mk_desc(UT_IDR, 5'd0, 8'd0, 1'b1));
		add(mk_desc(UT_SPS, 5'd31, 8'd0, 1'b0));
		add_verdict(mk_byte(8'hFF, 1'b1), ACT_KEY, 16'hFFFF, 16'hFFFF);
		// learn SPS 31 and PPS 255, then an IDR that takes its size
		add(mk_hdr(1'b0, 1'b0, 1'b0, 16'd1920, 16'd1080));
		add(mk_desc(UT_SPS, 5'd31, 8'd0, 1'b0));
		add(mk_desc(UT_PPS, 5'd31, 8'd255, 1'b1));
		add(mk_desc(UT_PPS, 5'd0, 8'd7, 1'b0));
		add(mk_byte(8'h00, 1'b1));
		add(mk_hdr(1'b1, 1'b0, 1'b1, 16'd0, 16'd0));
		add(mk_desc(UT_IDR, 5'd0, 8'd255, 1'b1));
		add(mk_byte(8'h65, 1'b0));
		add(mk_byte(8'hAA, 1'b1));
		// IDR without picture id on a first packet
		add(mk_hdr(1'b1, 1'b1, 1'b1, 16'd5, 16'd6));
		add(mk_desc(UT_IDR, 5'd0, 8'd255, 1'b0));
		add_verdict(mk_byte(8'h18, 1'b1), ACT_KEY, 16'd5, 16'd6);
		// aggregate: header only, zero-length unit, truncated body, cut length
		add(mk_hdr(1'b0, 1'b1, 1'b1, 16'd3, 16'd4));
		add_verdict(mk_byte(8'h18, 1'b1), ACT_INSERT, 16'd3, 16'd4);
		add(mk_byte(8'h18, 1'b0));
		add(mk_byte(8'h00, 1'b0));
		add(mk_byte(8'h00, 1'b0));
		add(mk_byte(8'h00, 1'b0));
		add(mk_byte(8'h05, 1'b0));
		add(mk_byte(8'h11, 1'b1));
		add(mk_byte(8'h18, 1'b0));
		add(mk_byte(8'hFF, 1'b1));
		add(mk_hdr(1'b0, 1'b0, 1'b0, 16'd1, 16'd2));
		add('{op: OP_NONE, default: '0});
		add(mk_byte(8'h42, 1'b1));

		foreach (directed[i]) begin
			send(directed[i].req);
			if (directed[i].typed) begin
				chk = expected_q[expected_q.size() - 1];
				if (chk !== directed[i].res) report($sformatf("directed row %0d verdict", i));
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 55; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 55; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			repeat (14) random_packet();
		end
		in_valid <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

### h264_param_set_tracker_annexb.f
rtl/core/pst_pkg.sv
rtl/core/pst_front.sv
rtl/core/pst_back.sv
rtl/core/h264_param_set_tracker_annexb.sv
bench/tb.sv
